// ===== src/chassis_serial_frame_decoder_core_assert.svh =====
// assertion macros shared by the frame decoder modules
// expects signals named clk and rst in the including module
`ifndef CHASSIS_SERIAL_FRAME_DECODER_CORE_ASSERT_SVH
`define CHASSIS_SERIAL_FRAME_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CSFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CSFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/csfd_pkg.sv =====
// shared constants, codes and types of the chassis serial frame decoder
// no dependencies
package csfd_pkg;

  // frame store geometry
  localparam int FRAME_BYTES = 64;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

  // framing bytes
  localparam logic [7:0] HDR_FIRST  = 8'hAE;
  localparam logic [7:0] HDR_SECOND = 8'hEA;
  localparam logic [7:0] TAIL_FIRST  = 8'hEF;
  localparam logic [7:0] TAIL_SECOND = 8'hFE;

  // frame kinds
  localparam logic [7:0] KIND_MOTOR  = 8'h07;
  localparam logic [7:0] KIND_EMPTYA = 8'h08;
  localparam logic [7:0] KIND_ODOM   = 8'hA7;
  localparam logic [7:0] KIND_IMU    = 8'hA0;
  localparam logic [7:0] KIND_REMOTE = 8'hA3;
  localparam logic [7:0] KIND_EMPTYB = 8'hAC;

  // length byte counts everything but header and tail
  localparam logic [8:0] LEN_EXTRA = 9'd4;
  // remote window widening
  localparam logic [16:0] RC_MARGIN = 17'd200;

  // result status codes
  localparam logic [2:0] ST_VALUE    = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_UNKNOWN  = 3'd2;
  localparam logic [2:0] ST_LEN_ERR  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_RC_LOW  = 2'd0;
  localparam logic [1:0] CFG_RC_HIGH = 2'd1;

  // capture side to unpack side
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
    logic             overflow;
  } csfd_frame_t;

  // one result item
  typedef struct packed {
    logic [7:0]  kind;
    logic [2:0]  status;
    logic [3:0]  index;
    logic [31:0] value;
    logic        rc_in_range;
    logic        last;
  } csfd_result_t;

endpackage

// ===== src/csfd_capture.sv =====
// byte capture: header hunt, frame store, tail detection
// depends on csfd_pkg and the assertion macro header
`include "chassis_serial_frame_decoder_core_assert.svh"

module csfd_capture import csfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        rx_byte,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data,
  output csfd_frame_t       frame
);

  logic [7:0]       prev;
  logic             in_frame;
  logic [CNT_W-1:0] count;
  logic             overflow;
  logic [7:0]       mem [FRAME_BYTES];
  logic             room;
  logic             hdr_hit;
  logic             tail_hit;

  assign room     = count < CNT_W'(FRAME_BYTES);
  assign hdr_hit  = (prev == HDR_FIRST) && (rx_byte == HDR_SECOND);
  assign tail_hit = (prev == TAIL_FIRST) && (rx_byte == TAIL_SECOND);

  // framing control
  always_ff @(posedge clk) begin
    if (rst) begin
      prev     <= '0;
      in_frame <= 1'b0;
      count    <= '0;
      overflow <= 1'b0;
    end else if (take) begin
      prev <= rx_byte;
      if (!in_frame) begin
        if (hdr_hit) begin
          in_frame <= 1'b1;
          count    <= CNT_W'(2);
          overflow <= 1'b0;
        end
      end else begin
        if (room) begin
          count <= count + CNT_W'(1);
        end else begin
          overflow <= 1'b1;
        end
        if (tail_hit) begin
          in_frame <= 1'b0;
        end
      end
    end
  end

  // frame store, header positions are never read back so they are not written
  always_ff @(posedge clk) begin
    if (take && in_frame && room) begin
      mem[count[ADDR_W-1:0]] <= rx_byte;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  assign frame.start    = take && in_frame && tail_hit;
  assign frame.count    = count;
  assign frame.overflow = overflow;

  `CSFD_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(FRAME_BYTES), "store count past depth")
  `CSFD_ASSERT_NXT(a_start_closes, frame.start, !in_frame && count >= CNT_W'(4),
    "closed frame still open or too short")
  `CSFD_ASSERT_NXT(a_header_opens, take && !in_frame && hdr_hit,
    in_frame && count == CNT_W'(2) && !overflow, "header did not open a frame")

endmodule

// ===== src/csfd_unpack.sv =====
// result sequencer: reads the stored frame one byte per step and shifts
// each byte into a value register; depends on csfd_pkg and the macro header
`include "chassis_serial_frame_decoder_core_assert.svh"

module csfd_unpack import csfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  csfd_frame_t       frame,
  input  logic [15:0]       rc_low,
  input  logic [15:0]       rc_high,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  output logic              busy,
  output logic              res_valid,
  input  logic              res_ready,
  output csfd_result_t      res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADDR = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [1:0] M_NONE = 2'd0;
  localparam logic [1:0] M_W32  = 2'd1;
  localparam logic [1:0] M_S16  = 2'd2;
  localparam logic [1:0] M_RC   = 2'd3;

  logic [1:0]       state;
  logic [1:0]       mode;
  logic             hdr;
  logic [CNT_W-1:0] pos;
  logic [2:0]       nleft;
  logic [3:0]       idx;
  logic [3:0]       idx_last;
  logic [31:0]      val;
  logic [7:0]       kind;
  logic [2:0]       status;
  logic             rc_ok;

  logic [7:0]  byte_in;
  logic [31:0] val_shift;
  logic [15:0] ch1;
  logic        ch1_ok;
  logic [2:0]  hdr_status;
  logic [1:0]  hdr_mode;
  logic [3:0]  hdr_last;
  logic        out_last;

  // bytes per value for a mode and result index
  function automatic logic [2:0] width_for(input logic [1:0] m, input logic [3:0] i);
    logic [2:0] w;
    w = 3'd1;
    unique case (m)
      M_W32:   w = 3'd4;
      M_S16:   w = 3'd2;
      M_RC:    w = (i < 4'd4) ? 3'd2 : 3'd1;
      default: w = 3'd1;
    endcase
    return w;
  endfunction

  // positions past the stored count read as zero
  assign byte_in   = (pos < frame.count) ? rd_data : 8'h00;
  assign val_shift = {val[23:0], byte_in};
  assign rd_addr   = pos[ADDR_W-1:0];

  // remote channel one window, widened on both sides
  assign ch1    = val_shift[15:0];
  assign ch1_ok = (({1'b0, ch1} + RC_MARGIN) >= {1'b0, rc_low}) &&
                  ({1'b0, ch1} <= ({1'b0, rc_high} + RC_MARGIN));

  // frame classification once length and kind are in
  always_comb begin
    hdr_status = ST_VALUE;
    hdr_mode   = M_NONE;
    hdr_last   = 4'd0;
    priority if (frame.overflow) begin
      hdr_status = ST_OVERFLOW;
    end else if (({1'b0, val[7:0]} + LEN_EXTRA) != 9'(frame.count)) begin
      hdr_status = ST_LEN_ERR;
    end else if (byte_in == KIND_MOTOR) begin
      hdr_mode = M_W32;
      hdr_last = 4'd11;
    end else if (byte_in == KIND_ODOM) begin
      hdr_mode = M_S16;
      hdr_last = 4'd2;
    end else if (byte_in == KIND_IMU) begin
      hdr_mode = M_S16;
      hdr_last = 4'd11;
    end else if (byte_in == KIND_REMOTE) begin
      hdr_mode = M_RC;
      hdr_last = 4'd9;
    end else if (byte_in == KIND_EMPTYA || byte_in == KIND_EMPTYB) begin
      hdr_status = ST_EMPTY;
    end else begin
      hdr_status = ST_UNKNOWN;
    end
  end

  assign out_last = (status != ST_VALUE) || (idx == idx_last);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode     <= M_NONE;
      hdr      <= 1'b0;
      pos      <= '0;
      nleft    <= '0;
      idx      <= '0;
      idx_last <= '0;
      val      <= '0;
      kind     <= '0;
      status   <= ST_VALUE;
      rc_ok    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (frame.start) begin
            state  <= S_ADDR;
            hdr    <= 1'b1;
            pos    <= CNT_W'(2);
            nleft  <= 3'd2;
            idx    <= '0;
            val    <= '0;
            rc_ok  <= 1'b0;
            status <= ST_VALUE;
            mode   <= M_NONE;
          end
        end
        S_ADDR: begin
          state <= S_DATA;
        end
        S_DATA: begin
          pos <= pos + CNT_W'(1);
          if (nleft != 3'd1) begin
            val   <= val_shift;
            nleft <= nleft - 3'd1;
            state <= S_ADDR;
          end else if (hdr) begin
            hdr      <= 1'b0;
            kind     <= byte_in;
            status   <= hdr_status;
            mode     <= hdr_mode;
            idx_last <= hdr_last;
            val      <= '0;
            nleft    <= width_for(hdr_mode, 4'd0);
            state    <= (hdr_status != ST_VALUE) ? S_OUT : S_ADDR;
          end else begin
            val   <= val_shift;
            state <= S_OUT;
            if (mode == M_RC && idx == 4'd0) begin
              rc_ok <= ch1_ok;
            end
          end
        end
        S_OUT: begin
          if (res_ready) begin
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 4'd1;
              val   <= '0;
              nleft <= width_for(mode, idx + 4'd1);
              state <= S_ADDR;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy      = state != S_IDLE;
  assign res_valid = state == S_OUT;

  always_comb begin
    res.kind        = kind;
    res.status      = status;
    res.index       = idx;
    res.value       = (mode == M_S16) ? {{16{val[15]}}, val[15:0]} : val;
    res.rc_in_range = rc_ok;
    res.last        = out_last;
  end

  `CSFD_ASSERT_IMP(a_start_idle, frame.start, state == S_IDLE, "frame closed while unpacking")
  `CSFD_ASSERT_NXT(a_last_frees, res_valid && res_ready && res.last, state == S_IDLE,
    "sequencer busy after last item")
  `CSFD_ASSERT_IMP(a_status_plain, res_valid && status != ST_VALUE,
    idx == 4'd0 && val == 32'd0 && !rc_ok, "status item carries data")

endmodule

// ===== src/chassis_serial_frame_decoder_core.sv =====
// top of the chassis serial frame decoder, on csfd_pkg, csfd_capture and csfd_unpack
// decoding: a tail byte starts it; length and kind are read first, then each payload
// byte through the registered frame store read, and each result waits for m_tready
// throughput: one input byte per cycle outside a frame drain, none during it
// reset: synchronous; hunting for a header, store count cleared, limits 1000/2000
module chassis_serial_frame_decoder_core import csfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input item: [7:0] rx_byte
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  // result item: [7:0] frame_kind, [10:8] status, [14:11] value_index,
  // [46:15] value, [47] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  // [0] rc_in_range
  output logic [0:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic              take;
  logic              busy;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  csfd_frame_t       frame;
  csfd_result_t      res;
  logic [15:0]       rc_low;
  logic [15:0]       rc_high;

  assign s_tready  = !busy;
  assign take      = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rc_low  <= 16'd1000;
      rc_high <= 16'd2000;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_RC_LOW) begin
        rc_low <= cfg_data;
      end else if (cfg_index == CFG_RC_HIGH) begin
        rc_high <= cfg_data;
      end
    end
  end

  csfd_capture u_capture (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (s_tdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .frame   (frame)
  );

  csfd_unpack u_unpack (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .rc_low    (rc_low),
    .rc_high   (rc_high),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .busy      (busy),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  // result packing
  assign m_tdata    = {1'b0, res.value, res.index, res.status, res.kind};
  assign m_tuser[0] = res.rc_in_range;
  assign m_tlast    = res.last;

endmodule
